@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the frame decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that a property holds at every clock edge outside reset.
`define SFD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sfd assertion failed");

// Check that a condition never becomes true outside reset.
`define SFD_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sfd forbidden condition seen");

`else

`define SFD_ASSERT(label, clk, rst_n, prop)
`define SFD_ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

@@ sv/sfd_pkg.sv @@
// Types and constants shared by the frame decoder modules.
`default_nettype none

package sfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int COUNTER_W  = 32;
    localparam int RAW_W      = 11;
    localparam int CHAN_NUM_W = 4;
    localparam int TDATA_W    = 80;
    localparam int CFG_ADDR_W = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_START_MARKER = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_END_MARKER   = 1'd1;

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd15;
    localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'd0;

    // Verdict and counter snapshot of one finished burst.
    typedef struct packed {
        logic                 good;
        logic [COUNTER_W-1:0] seen;
        logic [COUNTER_W-1:0] lost;
    } frame_info_t;

    // Fill status of the burst queue.
    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

`default_nettype wire

@@ sv/sfd_front.sv @@
// Byte intake: buffer the burst, count its length, judge it at burst end.
`default_nettype none

module sfd_front
    import sfd_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int CHANNEL_BITS = 11,
    parameter int FRAME_BYTES  = 25
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [BYTE_W-1:0]                    s_tdata,    // rx_byte
    input  wire logic                                 s_tlast,    // burst_end
    input  wire logic [BYTE_W-1:0]                    start_marker,
    input  wire logic [BYTE_W-1:0]                    end_marker,
    input  wire queue_status_t                        q_status,
    output logic                                      push,
    output frame_info_t                               push_info,
    output logic [NUM_CHANNELS*CHANNEL_BITS-1:0]      push_payload
);

    localparam int PAYLOAD_BITS = NUM_CHANNELS * CHANNEL_BITS;
    localparam int STORE_BYTES  = (PAYLOAD_BITS + BYTE_W - 1) / BYTE_W;
    localparam int CNT_W        = $clog2(FRAME_BYTES + 2);

    logic [CNT_W-1:0]              count_reg, count_next, count_after;
    logic [BYTE_W-1:0]             first_reg, first_next;
    logic [STORE_BYTES*BYTE_W-1:0] store_reg, store_next;
    logic [COUNTER_W-1:0]          total_reg, total_next;
    logic [COUNTER_W-1:0]          lost_reg, lost_next;
    logic                          accept;
    logic                          good;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && !q_status.full;

    always_comb
    begin
        count_next  = count_reg;
        first_next  = first_reg;
        store_next  = store_reg;
        total_next  = total_reg;
        lost_next   = lost_reg;
        count_after = count_reg;
        good        = 1'b0;
        push        = 1'b0;
        if (accept)
        begin
            if (count_reg == '0)
            begin
                first_next = s_tdata;
            end
            for (int i = 0; i < STORE_BYTES; i++)
            begin
                if (32'(count_reg) == 32'(i + 1))
                begin
                    store_next[i*BYTE_W +: BYTE_W] = s_tdata;
                end
            end
            // Saturate one past a full frame so long bursts stay bad.
            if (count_reg < CNT_W'(FRAME_BYTES + 1))
            begin
                count_after = count_reg + CNT_W'(1);
            end
            count_next = count_after;
            if (s_tlast)
            begin
                good = (count_after == CNT_W'(FRAME_BYTES)) &&
                       (first_reg == start_marker) && (s_tdata == end_marker);
                count_next = '0;
                total_next = total_reg + COUNTER_W'(1);
                lost_next  = lost_reg + COUNTER_W'(!good);
                push       = 1'b1;
            end
        end
    end

    assign push_info.good = good;
    assign push_info.seen = total_next;
    assign push_info.lost = lost_next;
    assign push_payload   = store_next[PAYLOAD_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            first_reg <= '0;
            total_reg <= '0;
            lost_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            first_reg <= first_next;
            total_reg <= total_next;
            lost_reg  <= lost_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

endmodule

`default_nettype wire

@@ sv/sfd_queue.sv @@
// Two-entry queue of judged bursts between intake and unpacking.
`default_nettype none

module sfd_queue
    import sfd_pkg::*;
#(
    parameter int PAYLOAD_BITS = 176
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire frame_info_t             push_info,
    input  wire logic [PAYLOAD_BITS-1:0] push_payload,
    input  wire logic                    pop,
    output queue_status_t                status,
    output frame_info_t                  head_info,
    output logic [PAYLOAD_BITS-1:0]      head_payload
);

    localparam int DEPTH = 2;

    frame_info_t             info_mem    [DEPTH];
    logic [PAYLOAD_BITS-1:0] payload_mem [DEPTH];
    logic                    wr_ptr_reg, rd_ptr_reg;
    logic [1:0]              fill_reg;

    assign status.full      = (fill_reg == 2'(DEPTH));
    assign status.not_empty = (fill_reg != 2'd0);
    assign head_info        = info_mem[rd_ptr_reg];
    assign head_payload     = payload_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            info_mem[wr_ptr_reg]    <= push_info;
            payload_mem[wr_ptr_reg] <= push_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

@@ sv/sfd_back.sv @@
// Result side: unpack channels of a queued burst, one result per cycle while the receiver is ready.
`default_nettype none

module sfd_back
    import sfd_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int CHANNEL_BITS = 11
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire queue_status_t                        q_status,
    input  wire frame_info_t                          head_info,
    input  wire logic [NUM_CHANNELS*CHANNEL_BITS-1:0] head_payload,
    output logic                                      pop,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [TDATA_W-1:0]                        m_tdata,
    output logic                                      m_tuser,
    output logic                                      m_tlast
);

    localparam int PAYLOAD_BITS = NUM_CHANNELS * CHANNEL_BITS;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic                    active_reg, active_next;
    frame_info_t             info_reg, info_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic [PAYLOAD_BITS-1:0] shift_reg, shift_next;

    logic                    valid_reg, valid_next;
    logic [CHAN_NUM_W-1:0]   num_reg, num_next;
    logic [RAW_W-1:0]        raw_reg, raw_next;
    logic                    good_reg, good_next;
    logic                    last_reg, last_next;
    logic [COUNTER_W-1:0]    seen_reg, seen_next;
    logic [COUNTER_W-1:0]    lost_reg, lost_next;

    logic                    advance;
    logic                    is_last;

    assign advance = !valid_reg || m_tready;
    assign is_last = !info_reg.good || (ch_reg == CH_W'(NUM_CHANNELS - 1));

    always_comb
    begin
        active_next = active_reg;
        info_next   = info_reg;
        ch_next     = ch_reg;
        shift_next  = shift_reg;
        valid_next  = valid_reg;
        num_next    = num_reg;
        raw_next    = raw_reg;
        good_next   = good_reg;
        last_next   = last_reg;
        seen_next   = seen_reg;
        lost_next   = lost_reg;
        pop         = 1'b0;
        if (active_reg && advance)
        begin
            valid_next = 1'b1;
            good_next  = info_reg.good;
            last_next  = is_last;
            seen_next  = info_reg.seen;
            lost_next  = info_reg.lost;
            if (info_reg.good)
            begin
                num_next = CHAN_NUM_W'(ch_reg);
                raw_next = RAW_W'(shift_reg[CHANNEL_BITS-1:0]);
            end
            else
            begin
                num_next = '0;
                raw_next = '0;
            end
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                ch_next    = ch_reg + CH_W'(1);
                shift_next = shift_reg >> CHANNEL_BITS;
            end
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        if (!active_reg && q_status.not_empty)
        begin
            pop         = 1'b1;
            active_next = 1'b1;
            info_next   = head_info;
            ch_next     = '0;
            shift_next  = head_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg  <= info_next;
        ch_reg    <= ch_next;
        shift_reg <= shift_next;
        num_reg   <= num_next;
        raw_reg   <= raw_next;
        good_reg  <= good_next;
        last_reg  <= last_next;
        seen_reg  <= seen_next;
        lost_reg  <= lost_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, lost_reg, seen_reg, raw_reg, num_reg};
    assign m_tuser  = good_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

@@ sv/sbus_frame_decoder_unit.sv @@
// Top level of the serial bus frame decoder.
// Receives serial-line bytes, one request per byte, with tlast marking the last byte
// before a line idle gap. A burst of exactly FRAME_BYTES bytes that opens with the
// start marker and closes with the end marker is a good frame and yields NUM_CHANNELS
// results carrying the raw CHANNEL_BITS-wide channel values, unpacked least
// significant bit first from the second byte on; any other burst yields one bad-frame
// result. Every result carries the running frame total and lost-frame count, both
// wrapping at 32 bits. The intake takes one byte per cycle; it judges a burst in the
// cycle its last byte arrives and parks it in a two-entry queue, and stops taking
// bytes only while both entries are occupied. The unpacker first loads a queued
// burst, then puts out one result per cycle from a shift register while the
// receiver is ready, and it loads the next burst only after the last result of
// the current one. Write the marker registers only while the block is idle.
`default_nettype none

`include "assert_macros.svh"

module sbus_frame_decoder_unit
    import sfd_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int CHANNEL_BITS = 11,
    parameter int FRAME_BYTES  = 25
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // byte input
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
    input  wire logic                  s_tlast,   // burst_end
    // results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [TDATA_W-1:0]         m_tdata,   // [3:0] channel_number,
                                                  // [14:4] channel_raw,
                                                  // [46:15] frames_seen,
                                                  // [78:47] frames_lost, [79] zero
    output logic                       m_tuser,   // [0] frame_good
    output logic                       m_tlast,   // last_of_frame
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [BYTE_W-1:0]     cfg_data
);

    localparam int PAYLOAD_BITS = NUM_CHANNELS * CHANNEL_BITS;

    logic [BYTE_W-1:0]       start_marker_reg;
    logic [BYTE_W-1:0]       end_marker_reg;

    queue_status_t           q_status;
    logic                    q_push;
    logic                    q_pop;
    frame_info_t             push_info;
    frame_info_t             head_info;
    logic [PAYLOAD_BITS-1:0] push_payload;
    logic [PAYLOAD_BITS-1:0] head_payload;

    // Marker registers: write-only, taken on any cycle with the enable high.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RESET;
            end_marker_reg   <= END_MARKER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_START_MARKER: start_marker_reg <= cfg_data;
                REG_END_MARKER:   end_marker_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Intake: buffer bytes, judge the burst, push the verdict and payload.
    sfd_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CHANNEL_BITS (CHANNEL_BITS),
        .FRAME_BYTES  (FRAME_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .start_marker (start_marker_reg),
        .end_marker   (end_marker_reg),
        .q_status     (q_status),
        .push         (q_push),
        .push_info    (push_info),
        .push_payload (push_payload)
    );

    // Hold up to two judged bursts so intake and unpacking stall apart.
    sfd_queue #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (q_push),
        .push_info    (push_info),
        .push_payload (push_payload),
        .pop          (q_pop),
        .status       (q_status),
        .head_info    (head_info),
        .head_payload (head_payload)
    );

    // Unpacker: drain a queued burst into results behind an output register.
    sfd_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head_info    (head_info),
        .head_payload (head_payload),
        .pop          (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    // Never push into a full queue.
    `SFD_ASSERT_NEVER(a_no_queue_overflow, clk, rst_n, q_push && q_status.full)
    // Never pop an empty queue.
    `SFD_ASSERT_NEVER(a_no_queue_underflow, clk, rst_n, q_pop && !q_status.not_empty)
    // A good frame ends on its highest channel.
    `SFD_ASSERT(a_good_last_channel, clk, rst_n,
        (m_tvalid && m_tuser && m_tlast) |->
            (m_tdata[3:0] == CHAN_NUM_W'(NUM_CHANNELS - 1)))
    // A bad-frame report is a single result with zero channel fields.
    `SFD_ASSERT(a_bad_report_form, clk, rst_n,
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata[14:0] == 15'd0)))

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the serial bus frame decoder unit.
`default_nettype none

module tb;
    import sfd_pkg::*;

    localparam int NUM_CHANNELS  = 16;
    localparam int CHANNEL_BITS  = 11;
    localparam int FRAME_BYTES   = 25;
    localparam int PAYLOAD_BYTES = FRAME_BYTES - 1;
    localparam int RAW_LSB       = CHAN_NUM_W;
    localparam int SEEN_LSB      = RAW_LSB + RAW_W;
    localparam int LOST_LSB      = SEEN_LSB + COUNTER_W;
    localparam int DRAIN_SETTLE  = 2 * NUM_CHANNELS;
    localparam int PHASE_BYTES   = 48;
    localparam int TIMEOUT       = 400000;

    typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;
    typedef enum logic [1:0] {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_PATTERN} ready_mode_t;

    // One decoded result as it leaves the block.
    typedef struct packed {
        logic [CHAN_NUM_W-1:0] chan;
        logic [RAW_W-1:0]      raw;
        logic                  good;
        logic                  last;
        logic [COUNTER_W-1:0]  seen;
        logic [COUNTER_W-1:0]  lost;
    } chan_result_t;

    // Frame predictor plus the queue of channel results still owed by the block.
    class frame_scoreboard;
        logic [BYTE_W-1:0]    start_marker;
        logic [BYTE_W-1:0]    end_marker;
        logic [BYTE_W-1:0]    first_byte;
        logic [BYTE_W-1:0]    payload [PAYLOAD_BYTES];
        int unsigned          byte_count;
        logic [COUNTER_W-1:0] seen_count;
        logic [COUNTER_W-1:0] lost_count;
        chan_result_t         owed_results [$];
        int unsigned          mismatches;
        int unsigned          results_checked;
        int unsigned          good_bursts;
        int unsigned          bad_bursts;

        function new();
            start_marker    = START_MARKER_RESET;
            end_marker      = END_MARKER_RESET;
            first_byte      = '0;
            byte_count      = 0;
            seen_count      = '0;
            lost_count      = '0;
            mismatches      = 0;
            results_checked = 0;
            good_bursts     = 0;
            bad_bursts      = 0;
            foreach (payload[i])
                payload[i] = '0;
        endfunction

        // Advance the frame state by one accepted byte; queue the results it causes.
        function void note_byte(input logic [BYTE_W-1:0] rx, input logic burst_end);
            chan_result_t r;
            int unsigned  pos;
            logic         is_good;
            if (byte_count == 0)
                first_byte = rx;
            else if (byte_count - 1 < PAYLOAD_BYTES)
                payload[byte_count - 1] = rx;
            // saturate one past a full frame so overlong bursts never look complete
            if (byte_count < FRAME_BYTES + 1)
                byte_count++;
            if (!burst_end)
                return;
            is_good = (byte_count == FRAME_BYTES) && (first_byte == start_marker)
                      && (rx == end_marker);
            byte_count = 0;
            seen_count++;
            if (!is_good) begin
                lost_count++;
                bad_bursts++;
                r.chan = '0;
                r.raw  = '0;
                r.good = 1'b0;
                r.last = 1'b1;
                r.seen = seen_count;
                r.lost = lost_count;
                owed_results.push_back(r);
                return;
            end
            good_bursts++;
            for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
                r.raw = '0;
                // channels are packed back to back, least significant bit first
                for (int b = 0; b < CHANNEL_BITS; b++) begin
                    pos = ch * CHANNEL_BITS + b;
                    r.raw[b] = payload[pos / BYTE_W][pos % BYTE_W];
                end
                r.chan = CHAN_NUM_W'(ch);
                r.good = 1'b1;
                r.last = (ch == NUM_CHANNELS - 1);
                r.seen = seen_count;
                r.lost = lost_count;
                owed_results.push_back(r);
            end
        endfunction

        task report(input string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task check_result(input chan_result_t got);
            chan_result_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected result chan %0d raw %0d good %0b",
                                 got.chan, got.raw, got.good));
                return;
            end
            want = owed_results.pop_front();
            results_checked++;
            if (got.chan !== want.chan)
                report($sformatf("channel_number %0d, want %0d", got.chan, want.chan));
            if (got.raw !== want.raw)
                report($sformatf("channel_raw %0d, want %0d (chan %0d)",
                                 got.raw, want.raw, want.chan));
            if (got.good !== want.good)
                report($sformatf("frame_good %0b, want %0b", got.good, want.good));
            if (got.last !== want.last)
                report($sformatf("last_of_frame %0b, want %0b (chan %0d)",
                                 got.last, want.last, want.chan));
            if (got.seen !== want.seen)
                report($sformatf("frames_seen %0d, want %0d", got.seen, want.seen));
            if (got.lost !== want.lost)
                report($sformatf("frames_lost %0d, want %0d", got.lost, want.lost));
        endtask

        task finish_check();
            if (owed_results.size() != 0)
                report($sformatf("%0d expected results never arrived", owed_results.size()));
        endtask

        function int unsigned pending();
            return owed_results.size();
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata  = '0;
    logic                  s_tlast  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [BYTE_W-1:0]     cfg_data = '0;

    frame_scoreboard sb;
    chan_result_t    observed_result;
    logic [31:0]     cycle_count = '0;
    int              run_left = 0;
    int              bytes_sent = 0;
    int              marker_settings = 1;

    sbus_frame_decoder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    // Receiver: rotate through always-ready, coin-flip, sparse and fixed stall patterns.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        case (ready_mode_t'(cycle_count[8:7]))
            READY_ALWAYS: m_tready <= 1'b1;
            READY_HALF:   m_tready <= ($urandom_range(0, 1) == 1);
            READY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:      m_tready <= (cycle_count[2:0] != 3'd0) && (cycle_count[4:3] != 2'd2);
        endcase
    end

    // Check every accepted result against the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            observed_result.chan = m_tdata[0 +: CHAN_NUM_W];
            observed_result.raw  = m_tdata[RAW_LSB +: RAW_W];
            observed_result.good = m_tuser;
            observed_result.last = m_tlast;
            observed_result.seen = m_tdata[SEEN_LSB +: COUNTER_W];
            observed_result.lost = m_tdata[LOST_LSB +: COUNTER_W];
            sb.check_result(observed_result);
        end
    end

    // Offer one byte request and hold it until accepted; idle between bursts of requests.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic burst_end);
        int gap;
        if (run_left == 0) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            // now and then a long stretch with no idling at all
            run_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end
        run_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= burst_end;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b, burst_end);
        bytes_sent++;
    endtask

    // Send one burst: head byte, filler, tail byte flagged as burst end.
    task automatic send_burst(input int len, input logic [BYTE_W-1:0] head,
                              input logic [BYTE_W-1:0] tail, input fill_t fill);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ONES:  b = '1;
                FILL_ZEROS: b = '0;
                default:    b = BYTE_W'($urandom_range(0, 255));
            endcase
            if (i == 0)
                b = head;
            else if (i == len - 1)
                b = tail;
            push_byte(b, i == len - 1);
        end
    endtask

    // Drop valid and hold until every owed result has come, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
    endtask

    // Write both marker registers back to back; call only with the block idle.
    task automatic set_markers(input logic [BYTE_W-1:0] start_value,
                               input logic [BYTE_W-1:0] end_value);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_START_MARKER;
        cfg_data <= start_value;
        @(posedge clk);
        cfg_addr <= REG_END_MARKER;
        cfg_data <= end_value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.start_marker = start_value;
        sb.end_marker   = end_value;
        marker_settings++;
    endtask

    // Mostly well-formed frames with random payload, plus near misses and noise.
    task automatic run_random_phase(input int byte_budget, input bit hold_midway);
        int first_count;
        int pick;
        int len;
        bit held;
        first_count = bytes_sent;
        held = 1'b0;
        while (bytes_sent - first_count < byte_budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_burst(FRAME_BYTES, sb.start_marker, sb.end_marker, FILL_RANDOM);
            end else if (pick < 70) begin
                len = $urandom_range(0, 1) ? FRAME_BYTES - 1 : FRAME_BYTES + 1;
                send_burst(len, sb.start_marker, sb.end_marker, FILL_RANDOM);
            end else if (pick < 78) begin
                send_burst(FRAME_BYTES, sb.start_marker ^ BYTE_W'($urandom_range(1, 255)),
                           sb.end_marker, FILL_RANDOM);
            end else if (pick < 86) begin
                send_burst(FRAME_BYTES, sb.start_marker,
                           sb.end_marker ^ BYTE_W'($urandom_range(1, 255)), FILL_RANDOM);
            end else if (pick < 95) begin
                send_burst($urandom_range(1, 8), BYTE_W'($urandom_range(0, 255)),
                           BYTE_W'($urandom_range(0, 255)), FILL_RANDOM);
            end else begin
                // overlong, including lengths that would alias a full frame
                // if the byte count wrapped instead of saturating
                send_burst($urandom_range(FRAME_BYTES + 1, 60), sb.start_marker,
                           sb.end_marker, FILL_RANDOM);
            end
            if (hold_midway && !held && bytes_sent - first_count >= byte_budget / 2) begin
                drain();
                held = 1'b1;
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset markers, payload extremes, a lone byte and an overlong burst.
        send_burst(FRAME_BYTES, START_MARKER_RESET, END_MARKER_RESET, FILL_ONES);
        send_burst(FRAME_BYTES, START_MARKER_RESET, END_MARKER_RESET, FILL_ZEROS);
        send_burst(1, START_MARKER_RESET, END_MARKER_RESET, FILL_RANDOM);
        send_burst(FRAME_BYTES + 1, START_MARKER_RESET, END_MARKER_RESET, FILL_ONES);
        drain();

        // Random phases under a series of marker settings, extremes first.
        set_markers('0, '1);
        run_random_phase(PHASE_BYTES, 1'b1);
        drain();
        set_markers('1, '0);
        run_random_phase(PHASE_BYTES, 1'b0);
        drain();
        set_markers('1, '1);
        run_random_phase(PHASE_BYTES, 1'b0);
        drain();
        set_markers(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
        run_random_phase(PHASE_BYTES, 1'b0);
        drain();

        sb.finish_check();
        $display("Run covered %0d bytes in %0d bursts (%0d good frames, %0d bad)",
                 bytes_sent, sb.good_bursts + sb.bad_bursts, sb.good_bursts, sb.bad_bursts);
        $display("%0d results checked under %0d marker settings",
                 sb.results_checked, marker_settings);
        if (sb.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: end a hung run.
    initial
    begin
        #(TIMEOUT);
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
